// ===== src/pn3_pkg.sv =====
// Shared types and constants for the 3D gradient noise unit.
// Holds the field widths, opcodes, sequencer state and the table port struct.
// No dependencies.
package pn3_pkg;

  localparam int TABLE_SIZE    = 256;
  localparam int IDX_W         = $clog2(TABLE_SIZE);
  localparam int ENTRY_W       = 8;
  localparam int COORD_W       = 24;
  localparam int OUT_W         = 18;
  localparam int FRAC_BITS_DEF = 16;
  localparam int OUT_MAX       = 131071;
  localparam int OUT_MIN       = -131072;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
  } mem_req_t;

endpackage

// ===== src/perlin_noise_3d_unit.sv =====
// Top level of the 3D improved gradient noise unit: sequencer and datapath.
// Depends on pn3_pkg, pn3_perm_mem and pn3_mul_rnd.
//
// Usage. A word is offered on the in_ ports with start; it is taken at a rising
// edge where start is high and busy is low. A load word (in_opcode low) writes
// in_entry_value into permutation entry in_entry_index in that same cycle and
// gives no result; busy stays low, so loads can follow each other every cycle.
// An evaluate word (in_opcode high) raises busy. During the busy period the
// single table read port walks the hash chain and the eight corner
// lookups (14 reads), while the one shared multiplier first forms the three
// fade values (12 products) and then the seven interpolations. The result
// appears on out_noise_value with out_valid for exactly one cycle, in the
// cycle where busy is low again; a new word can be taken in that same cycle.
// The receiver cannot stall the result.
// Reset clears the sequencer and the strobe; the table keeps whatever it held
// and must be loaded before any entry is used.
module perlin_noise_3d_unit #(
  parameter int FRAC_BITS = pn3_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_opcode,
  input  logic        [pn3_pkg::IDX_W-1:0]   in_entry_index,
  input  logic        [pn3_pkg::ENTRY_W-1:0] in_entry_value,
  input  logic signed [pn3_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [pn3_pkg::COORD_W-1:0] in_coord_y,
  input  logic signed [pn3_pkg::COORD_W-1:0] in_coord_z,
  output logic                               out_valid,
  output logic signed [pn3_pkg::OUT_W-1:0]   out_noise_value
);
  import pn3_pkg::*;

  localparam int F  = FRAC_BITS;
  localparam int MA = F + 2;
  localparam int MB = F + 5;
  localparam int RW = F + 7;
  localparam int VW = F + 4;
  localparam int CW = (RW > OUT_W + 1) ? RW : OUT_W + 1;
  localparam int STEP_W = 5;

  localparam logic [STEP_W-1:0] STEP_A         = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_B         = STEP_W'(2);
  localparam logic [STEP_W-1:0] STEP_AA        = STEP_W'(3);
  localparam logic [STEP_W-1:0] STEP_AB        = STEP_W'(4);
  localparam logic [STEP_W-1:0] STEP_BA        = STEP_W'(5);
  localparam logic [STEP_W-1:0] STEP_BB        = STEP_W'(6);
  localparam logic [STEP_W-1:0] STEP_GRAD0     = STEP_W'(7);
  localparam logic [STEP_W-1:0] STEP_GRADN     = STEP_W'(14);
  localparam logic [STEP_W-1:0] STEP_FADE_LAST = STEP_W'(11);
  localparam logic [STEP_W-1:0] STEP_FADE_DONE = STEP_W'(12);
  localparam logic [STEP_W-1:0] STEP_LERP0     = STEP_W'(15);
  localparam logic [STEP_W-1:0] STEP_LAST      = STEP_W'(28);

  localparam logic [STEP_W-2:0] RD_CELL = (STEP_W-1)'(0);
  localparam logic [STEP_W-2:0] RD_A    = (STEP_W-1)'(1);
  localparam logic [STEP_W-2:0] RD_B    = (STEP_W-1)'(2);
  localparam logic [STEP_W-2:0] RD_AA   = (STEP_W-1)'(3);
  localparam logic [STEP_W-2:0] RD_AB   = (STEP_W-1)'(4);
  localparam logic [STEP_W-2:0] RD_BA   = (STEP_W-1)'(5);
  localparam logic [STEP_W-2:0] RD_BB   = (STEP_W-1)'(6);

  localparam logic [1:0] SUB_SQ    = 2'd0;
  localparam logic [1:0] SUB_TA    = 2'd1;
  localparam logic [1:0] SUB_CUBE  = 2'd2;
  localparam logic [1:0] SUB_FADE  = 2'd3;

  localparam logic signed [MB-1:0] TEN_ONE     = MB'(10) << F;
  localparam logic signed [MB-1:0] FIFTEEN_ONE = MB'(15) << F;
  localparam logic signed [VW-1:0] ONE_V       = VW'(1) << F;

  function automatic logic signed [VW-1:0] grad(input logic [3:0] h,
                                               input logic signed [VW-1:0] gx,
                                               input logic signed [VW-1:0] gy,
                                               input logic signed [VW-1:0] gz);
    logic signed [VW-1:0] u;
    logic signed [VW-1:0] v;
    u = h[3] ? gy : gx;
    if (!h[3] && !h[2]) begin
      v = gy;
    end else if (h == 4'd12 || h == 4'd14) begin
      v = gx;
    end else begin
      v = gz;
    end
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                accept, eval_acc, load_acc;

  logic signed [COORD_W-1:0]       coord_in [3];
  logic [IDX_W-1:0]                cell_r [3];
  logic [F-1:0]                    frac_r [3];
  logic [IDX_W-1:0]                a_r, b_r, aa_r, ab_r, ba_r, bb_r;
  logic signed [MA-1:0]            fade_r [3];
  logic signed [MA-1:0]            t2_r;
  logic signed [MB-1:0]            bq_r;
  logic signed [VW-1:0]            line_r [8];

  mem_req_t             mem_req;
  logic [ENTRY_W-1:0]   rd_data;
  logic [IDX_W-1:0]     rd_base;

  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;
  logic signed [RW-1:0] mul_res;

  logic                 fade_phase, grad_phase, lerp_phase, lerp_shift;
  logic [1:0]           fax, fsub, pax, psub;
  logic [STEP_W-1:0]    step_prev, grad_k, lerp_k;
  logic [2:0]           lerp_i;
  logic [F-1:0]         t_cur;
  logic signed [VW-1:0] ofs_x, ofs_y, ofs_z, grad_val, tap_a, tap_b, tail;
  logic signed [MA-1:0] fade_sel;
  logic signed [RW-1:0] lerp_sum;
  logic signed [CW-1:0] wide;
  logic signed [OUT_W-1:0] clamp_val;
  logic                 out_valid_r;
  logic signed [OUT_W-1:0] out_noise_r;

  assign accept   = start && !busy;
  assign eval_acc = accept && (in_opcode == OP_EVAL);
  assign load_acc = accept && (in_opcode == OP_LOAD);
  assign busy     = (state_r == ST_RUN);

  assign coord_in[0] = in_coord_x;
  assign coord_in[1] = in_coord_y;
  assign coord_in[2] = in_coord_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= busy && (step_r == STEP_LAST);
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        step_nxt = '0;
        if (eval_acc) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (step_r == STEP_LAST) begin
          state_nxt = ST_IDLE;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        step_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (eval_acc) begin
      for (int i = 0; i < 3; i++) begin
        cell_r[i] <= IDX_W'({{IDX_W{coord_in[i][COORD_W-1]}}, coord_in[i]} >> F);
        frac_r[i] <= coord_in[i][F-1:0];
      end
    end
  end

  always_comb begin
    unique case (step_r[STEP_W-1:1])
      RD_CELL: rd_base = cell_r[0];
      RD_A:    rd_base = a_r;
      RD_B:    rd_base = b_r;
      RD_AA:   rd_base = aa_r;
      RD_AB:   rd_base = ab_r;
      RD_BA:   rd_base = ba_r;
      RD_BB:   rd_base = bb_r;
      default: rd_base = bb_r;
    endcase
    mem_req.wr_en   = load_acc;
    mem_req.wr_addr = in_entry_index;
    mem_req.wr_data = in_entry_value;
    mem_req.rd_en   = busy;
    mem_req.rd_addr = rd_base + IDX_W'(step_r[0]);
  end

  pn3_perm_mem u_perm_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (busy) begin
      if (step_r == STEP_A)  a_r  <= rd_data + cell_r[1];
      if (step_r == STEP_B)  b_r  <= rd_data + cell_r[1];
      if (step_r == STEP_AA) aa_r <= rd_data + cell_r[2];
      if (step_r == STEP_AB) ab_r <= rd_data + cell_r[2];
      if (step_r == STEP_BA) ba_r <= rd_data + cell_r[2];
      if (step_r == STEP_BB) bb_r <= rd_data + cell_r[2];
    end
  end

  assign fade_phase = busy && (step_r <= STEP_FADE_LAST);
  assign fax        = step_r[3:2];
  assign fsub       = step_r[1:0];
  assign step_prev  = step_r - STEP_W'(1);
  assign pax        = step_prev[3:2];
  assign psub       = step_prev[1:0];
  assign t_cur      = frac_r[fax];

  assign grad_phase = busy && (step_r >= STEP_GRAD0) && (step_r <= STEP_GRADN);
  assign grad_k     = step_r - STEP_GRAD0;
  assign ofs_x      = grad_k[2] ? $signed({4'b0000, frac_r[0]}) - ONE_V
                                : $signed({4'b0000, frac_r[0]});
  assign ofs_y      = grad_k[1] ? $signed({4'b0000, frac_r[1]}) - ONE_V
                                : $signed({4'b0000, frac_r[1]});
  assign ofs_z      = grad_k[0] ? $signed({4'b0000, frac_r[2]}) - ONE_V
                                : $signed({4'b0000, frac_r[2]});
  assign grad_val   = grad(rd_data[3:0], ofs_x, ofs_y, ofs_z);

  assign lerp_phase = busy && (step_r >= STEP_LERP0);
  assign lerp_k     = step_r - STEP_LERP0;
  assign lerp_i     = lerp_k[3:1];
  assign lerp_shift = lerp_phase && lerp_k[0];

  always_comb begin
    priority if (lerp_i < 3'd4) begin
      tap_a    = line_r[0];
      tap_b    = line_r[4];
      fade_sel = fade_r[0];
    end else if (lerp_i < 3'd6) begin
      tap_a    = line_r[4];
      tap_b    = line_r[6];
      fade_sel = fade_r[1];
    end else begin
      tap_a    = line_r[6];
      tap_b    = line_r[7];
      fade_sel = fade_r[2];
    end
  end

  always_comb begin
    if (fade_phase) begin
      unique case (fsub)
        SUB_SQ: begin
          mul_a = $signed({2'b00, t_cur});
          mul_b = $signed({5'b00000, t_cur});
        end
        SUB_TA: begin
          mul_a = $signed({2'b00, t_cur});
          mul_b = ($signed({5'b00000, t_cur}) <<< 2) + ($signed({5'b00000, t_cur}) <<< 1)
                  - FIFTEEN_ONE;
        end
        SUB_CUBE: begin
          mul_a = t2_r;
          mul_b = $signed({5'b00000, t_cur});
        end
        SUB_FADE: begin
          mul_a = mul_res[MA-1:0];
          mul_b = bq_r;
        end
        default: begin
          mul_a = t2_r;
          mul_b = bq_r;
        end
      endcase
    end else begin
      mul_a = fade_sel;
      mul_b = MB'(tap_b) - MB'(tap_a);
    end
  end

  pn3_mul_rnd #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul_rnd (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .res  (mul_res)
  );

  always_ff @(posedge clk) begin
    if (busy && (step_r >= STEP_A) && (step_r <= STEP_FADE_DONE)) begin
      unique case (psub)
        SUB_SQ:   t2_r        <= mul_res[MA-1:0];
        SUB_TA:   bq_r        <= mul_res[MB-1:0] + TEN_ONE;
        SUB_CUBE: t2_r        <= t2_r;
        SUB_FADE: fade_r[pax] <= mul_res[MA-1:0];
        default:  t2_r        <= t2_r;
      endcase
    end
  end

  assign lerp_sum = RW'(tap_a) + mul_res;
  assign tail     = grad_phase ? grad_val : lerp_sum[VW-1:0];
  assign wide     = CW'(lerp_sum);

  always_comb begin
    priority if (wide > CW'(OUT_MAX)) begin
      clamp_val = OUT_W'(OUT_MAX);
    end else if (wide < CW'(OUT_MIN)) begin
      clamp_val = OUT_W'(OUT_MIN);
    end else begin
      clamp_val = wide[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (grad_phase || lerp_shift) begin
      for (int i = 0; i < 7; i++) begin
        line_r[i] <= line_r[i+1];
      end
      line_r[7] <= tail;
    end
    if (busy && (step_r == STEP_LAST)) begin
      out_noise_r <= clamp_val;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_noise_value = out_noise_r;

  a_strobe_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy)
    else $error("result strobe while the sequencer is running");

  a_eval_starts: assert property (@(posedge clk) disable iff (!rst_n)
    eval_acc |=> (busy && step_r == '0))
    else $error("evaluate word did not start the sequencer at its first step");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    load_acc |=> (!busy && !out_valid_r))
    else $error("load word started work or produced a result");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && step_r == STEP_LAST) |=> out_valid_r)
    else $error("final step did not deliver a result");

endmodule

// ===== src/pn3_perm_mem.sv =====
// Permutation table storage: one write port and one read port, registered read.
// Depends on pn3_pkg for the table size and the port struct.
module pn3_perm_mem (
  input  logic                      clk,
  input  pn3_pkg::mem_req_t         req,
  output logic [pn3_pkg::ENTRY_W-1:0] rd_data
);
  import pn3_pkg::*;

  logic [ENTRY_W-1:0] mem_r [TABLE_SIZE];
  logic [ENTRY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem_r[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/pn3_mul_rnd.sv =====
// Shared signed multiplier with round-to-nearest rescaling and a result register.
// Depends on pn3_pkg only through the parameter default.
module pn3_mul_rnd #(
  parameter int FRAC_BITS = pn3_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic signed [FRAC_BITS+1:0] op_a,
  input  logic signed [FRAC_BITS+4:0] op_b,
  output logic signed [FRAC_BITS+6:0] res
);
  import pn3_pkg::*;

  localparam int MA = FRAC_BITS + 2;
  localparam int MB = FRAC_BITS + 5;
  localparam int RW = FRAC_BITS + 7;
  localparam int PW = MA + MB;
  localparam logic signed [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] sum;
  logic signed [RW-1:0] res_r;

  assign prod = op_a * op_b;
  assign sum  = prod + HALF;

  always_ff @(posedge clk) begin
    res_r <= sum[PW-1:FRAC_BITS];
  end

  assign res = res_r;

endmodule

// ===== tb/sv/perlin_noise_3d_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for perlin_noise_3d_unit: fills the permutation table,
// walks a directed table of words, then random words, checking every noise result.
// Depends on pn3_pkg and the perlin_noise_3d_unit RTL.
module perlin_noise_3d_unit_tb;
  import pn3_pkg::*;

  localparam int     FB        = FRAC_BITS_DEF;
  localparam longint UNIT      = longint'(1) <<< FB;
  localparam int     N_RANDOM  = 1424;
  localparam int     N_DIR     = 20;
  localparam int     DUE_DEPTH = 4;

  typedef struct packed {
    logic                      op;
    logic [IDX_W-1:0]          idx;
    logic [ENTRY_W-1:0]        val;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      typed;
    logic signed [OUT_W-1:0]   want;
  } dir_row_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic                      in_opcode = OP_LOAD;
  logic [IDX_W-1:0]          in_entry_index = '0;
  logic [ENTRY_W-1:0]        in_entry_value = '0;
  logic signed [COORD_W-1:0] in_coord_x = '0;
  logic signed [COORD_W-1:0] in_coord_y = '0;
  logic signed [COORD_W-1:0] in_coord_z = '0;
  logic                      out_valid;
  logic signed [OUT_W-1:0]   out_noise_value;

  logic [ENTRY_W-1:0]      perm_copy [TABLE_SIZE];
  logic signed [OUT_W-1:0] noise_due [DUE_DEPTH];
  int                      due_in = 0;
  int                      due_out = 0;
  int                      mismatches = 0;

  dir_row_t dir_rows [N_DIR] = '{
    '{OP_EVAL, 8'h00, 8'h00, 24'h000000, 24'h000000, 24'h000000, 1'b1, 18'sd0},
    '{OP_EVAL, 8'h00, 8'h00, 24'h800000, 24'h800000, 24'h800000, 1'b1, 18'sd0},
    '{OP_EVAL, 8'h00, 8'h00, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0, 18'sd0},
    '{OP_EVAL, 8'hFF, 8'hFF, 24'h010000, 24'h020000, 24'h030000, 1'b1, 18'sd0},
    '{OP_EVAL, 8'h00, 8'h00, 24'h008000, 24'h000000, 24'h000000, 1'b0, 18'sd0},
    '{OP_EVAL, 8'h00, 8'h00, 24'h00FFFF, 24'h00FFFF, 24'h00FFFF, 1'b0, 18'sd0},
    '{OP_EVAL, 8'h00, 8'h00, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 18'sd0},
    '{OP_EVAL, 8'h00, 8'h00, 24'h7F8000, 24'h808000, 24'h000001, 1'b0, 18'sd0},
    '{OP_EVAL, 8'h00, 8'h00, 24'hFFFFFF, 24'h7FFFFF, 24'h800000, 1'b0, 18'sd0},
    '{OP_LOAD, 8'h00, 8'hFF, 24'h123456, 24'hABCDEF, 24'h7FFFFF, 1'b0, 18'sd0},
    '{OP_LOAD, 8'hFF, 8'h00, 24'h800000, 24'hFFFFFF, 24'h555555, 1'b0, 18'sd0},
    '{OP_EVAL, 8'h00, 8'h00, 24'hFF8000, 24'hFF8000, 24'hFF8000, 1'b0, 18'sd0},
    '{OP_EVAL, 8'hAA, 8'h55, 24'h012345, 24'hFEDCBA, 24'h0A5A5A, 1'b0, 18'sd0},
    '{OP_LOAD, 8'h80, 8'h0F, 24'h000000, 24'h000000, 24'h000000, 1'b0, 18'sd0},
    '{OP_LOAD, 8'h7F, 8'hF0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 18'sd0},
    '{OP_EVAL, 8'h00, 8'h00, 24'h7F8000, 24'h7F8000, 24'h7F8000, 1'b0, 18'sd0},
    '{OP_EVAL, 8'hFF, 8'hFF, 24'hFD0000, 24'h050000, 24'h7F0000, 1'b1, 18'sd0},
    '{OP_EVAL, 8'h00, 8'h00, 24'h7FFFFF, 24'h800000, 24'h000001, 1'b0, 18'sd0},
    '{OP_EVAL, 8'h00, 8'h00, 24'h00C000, 24'h004000, 24'h00E000, 1'b0, 18'sd0},
    '{OP_EVAL, 8'h00, 8'h00, 24'h808000, 24'h7FC000, 24'hFFC000, 1'b0, 18'sd0}
  };

  perlin_noise_3d_unit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_entry_index (in_entry_index),
    .in_entry_value (in_entry_value),
    .in_coord_x     (in_coord_x),
    .in_coord_y     (in_coord_y),
    .in_coord_z     (in_coord_z),
    .out_valid      (out_valid),
    .out_noise_value(out_noise_value)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic longint round_q(input longint p);
    return (p + (longint'(1) <<< (FB - 1))) >>> FB;
  endfunction

  function automatic longint fade_q(input longint t);
    longint a;
    longint b;
    longint t2;
    longint t3;
    a  = 6 * t - 15 * UNIT;
    b  = round_q(t * a) + 10 * UNIT;
    t2 = round_q(t * t);
    t3 = round_q(t2 * t);
    return round_q(t3 * b);
  endfunction

  function automatic longint lerp_q(input longint a, input longint b, input longint f);
    return a + round_q(f * (b - a));
  endfunction

  function automatic longint grad_dot(input logic [7:0] code, input longint dx,
                                      input longint dy, input longint dz);
    logic [3:0] h;
    longint     u;
    longint     v;
    h = code[3:0];
    u = (h < 4'd8) ? dx : dy;
    if (h < 4'd4) begin
      v = dy;
    end else if (h == 4'd12 || h == 4'd14) begin
      v = dx;
    end else begin
      v = dz;
    end
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic logic [7:0] perm_at(input logic [7:0] i);
    return perm_copy[i];
  endfunction

  function automatic logic signed [OUT_W-1:0] noise_at(input logic signed [COORD_W-1:0] px,
                                                       input logic signed [COORD_W-1:0] py,
                                                       input logic signed [COORD_W-1:0] pz);
    longint     crd [3];
    longint     fr [3];
    longint     fd [3];
    logic [7:0] cell_idx [3];
    longint     fl;
    logic [7:0] a, b, aa, ab, ba, bb;
    longint     x1, y1, z1;
    longint     g000, g100, g010, g110, g001, g101, g011, g111;
    longint     r;
    crd[0] = px;
    crd[1] = py;
    crd[2] = pz;
    for (int k = 0; k < 3; k++) begin
      fl          = crd[k] >>> FB;
      cell_idx[k] = fl[7:0];
      fr[k]       = crd[k] - fl * UNIT;
      fd[k]       = fade_q(fr[k]);
    end
    a  = perm_at(cell_idx[0]) + cell_idx[1];
    aa = perm_at(a) + cell_idx[2];
    ab = perm_at(a + 8'd1) + cell_idx[2];
    b  = perm_at(cell_idx[0] + 8'd1) + cell_idx[1];
    ba = perm_at(b) + cell_idx[2];
    bb = perm_at(b + 8'd1) + cell_idx[2];
    x1 = fr[0] - UNIT;
    y1 = fr[1] - UNIT;
    z1 = fr[2] - UNIT;
    g000 = grad_dot(perm_at(aa), fr[0], fr[1], fr[2]);
    g100 = grad_dot(perm_at(ba), x1, fr[1], fr[2]);
    g010 = grad_dot(perm_at(ab), fr[0], y1, fr[2]);
    g110 = grad_dot(perm_at(bb), x1, y1, fr[2]);
    g001 = grad_dot(perm_at(aa + 8'd1), fr[0], fr[1], z1);
    g101 = grad_dot(perm_at(ba + 8'd1), x1, fr[1], z1);
    g011 = grad_dot(perm_at(ab + 8'd1), fr[0], y1, z1);
    g111 = grad_dot(perm_at(bb + 8'd1), x1, y1, z1);
    r = lerp_q(lerp_q(lerp_q(g000, g100, fd[0]), lerp_q(g010, g110, fd[0]), fd[1]),
               lerp_q(lerp_q(g001, g101, fd[0]), lerp_q(g011, g111, fd[0]), fd[1]),
               fd[2]);
    if (r > OUT_MAX) r = OUT_MAX;
    if (r < OUT_MIN) r = OUT_MIN;
    return r[OUT_W-1:0];
  endfunction

  function automatic logic signed [COORD_W-1:0] coord_pick();
    logic [15:0] frac;
    int          v;
    case ($urandom_range(0, 4))
      0: frac = 16'h0000;
      1: frac = 16'h0001;
      2: frac = 16'hFFFF;
      3: frac = 16'h8000;
      default: frac = 16'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0: return COORD_W'($urandom);
      1: return {8'($urandom), frac};
      2: begin
        v = int'($urandom_range(0, 32'(4 * UNIT))) - int'(2 * UNIT);
        return v[COORD_W-1:0];
      end
      default: begin
        case ($urandom_range(0, 3))
          0: return {8'h80, frac};
          1: return {8'h7F, frac};
          2: return {8'hFF, frac};
          default: return {8'h00, frac};
        endcase
      end
    endcase
  endfunction

  // Offers one word, holding it until the unit takes it, then books the outcome.
  task automatic issue_word(input logic op, input logic [IDX_W-1:0] idx,
                            input logic [ENTRY_W-1:0] val,
                            input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y,
                            input logic signed [COORD_W-1:0] z,
                            input bit typed, input logic signed [OUT_W-1:0] want,
                            input int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    in_opcode      <= op;
    in_entry_index <= idx;
    in_entry_value <= val;
    in_coord_x     <= x;
    in_coord_y     <= y;
    in_coord_z     <= z;
    do @(posedge clk); while (busy);
    if (op == OP_LOAD) begin
      perm_copy[idx] = val;
    end else begin
      noise_due[due_in[1:0]] = typed ? want : noise_at(x, y, z);
      due_in++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (due_in == due_out) begin
        $display("%0t: unexpected word: expected none, actual %0d", $time, out_noise_value);
        mismatches++;
      end else begin
        if (out_noise_value !== noise_due[due_out[1:0]]) begin
          $display("%0t: noise mismatch: expected %0d, actual %0d",
                   $time, noise_due[due_out[1:0]], out_noise_value);
          mismatches++;
        end
        due_out++;
      end
    end
  end

  initial begin
    int   idle_pct;
    logic op;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < TABLE_SIZE; i++) begin
      issue_word(OP_LOAD, i[7:0], 8'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                 COORD_W'($urandom), 1'b0, '0, 20);
    end

    foreach (dir_rows[i]) begin
      issue_word(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].val, dir_rows[i].x,
                 dir_rows[i].y, dir_rows[i].z, dir_rows[i].typed, dir_rows[i].want, 20);
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i < N_RANDOM / 3) begin
        idle_pct = 38;
      end else if (i < 2 * N_RANDOM / 3) begin
        idle_pct = 46;
      end else begin
        idle_pct = 0;
      end
      op = ($urandom_range(0, 99) < 15) ? OP_LOAD : OP_EVAL;
      issue_word(op, 8'($urandom), 8'($urandom), coord_pick(), coord_pick(), coord_pick(),
                 1'b0, '0, idle_pct);
    end
    start <= 1'b0;

    while (due_in != due_out) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
